// ===== design/nmea_rmc_field_extractor_top_assert.svh =====
// Assertion macros for the RMC field extractor checker.
// Both expect signals named clock and reset in the using scope.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication
`define NRFE_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define NRFE_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/nrfe_pkg.sv =====
package nrfe_pkg;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_HUNT    = 7'b0000010,
      PH_COMMAS  = 7'b0000100,
      PH_STATUS  = 7'b0001000,
      PH_CAPTURE = 7'b0010000,
      PH_SKIP    = 7'b0100000,
      PH_DISCARD = 7'b1000000
   } phase_type;

   localparam logic       OP_BYTE  = 1'b0;
   localparam logic       OP_START = 1'b1;

   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_FIX     = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_LAT    = 2'd1;
   localparam logic [1:0] MODE_LON    = 2'd2;
   localparam logic [1:0] MODE_TIME   = 2'd3;

   localparam logic       CSR_FIELD_MODE    = 1'b0;
   localparam logic       CSR_TIMEOUT_BYTES = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd3960;

   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_A     = 8'h41;

   localparam logic [4:0] LEN_LON     = 5'd13;
   localparam logic [4:0] LEN_OTHER   = 5'd12;
   localparam logic [3:0] TIME_END    = 4'd5;
   localparam logic [3:0] DATE_START  = 4'd6;
   localparam logic [2:0] DISCARD_LEN = 3'd7;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_char;
      logic [3:0] out_index;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   function automatic logic [3:0] comma_target(input logic [1:0] mode);
      logic [3:0] t;
      case (mode)
         MODE_STATUS: t = 4'd2;
         MODE_LAT:    t = 4'd3;
         MODE_LON:    t = 4'd5;
         default:     t = 4'd8;
      endcase
      return t;
   endfunction

endpackage

// ===== design/nrfe_core.sv =====
module nrfe_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  nrfe_pkg::req_type   req_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_data,
   output nrfe_pkg::result_type result
);

   logic [1:0]  field_mode_ff;
   logic [15:0] timeout_ff;

   nrfe_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  comma_ff, comma_in;
   logic [3:0]  char_ff, char_in;
   logic [15:0] miss_ff, miss_in;
   logic [2:0]  discard_ff, discard_in;

   logic [3:0]  comma_sum;
   logic [15:0] miss_sum;
   logic [15:0] limit;
   logic [4:0]  idx_next;
   logic [4:0]  len;
   logic [7:0]  b;
   logic        is_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff <= nrfe_pkg::MODE_STATUS;
         timeout_ff    <= nrfe_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nrfe_pkg::CSR_FIELD_MODE:    field_mode_ff <= csr_data[1:0];
            nrfe_pkg::CSR_TIMEOUT_BYTES: timeout_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign b         = req_data.rx_byte;
   assign is_time   = (field_mode_ff == nrfe_pkg::MODE_TIME);
   assign comma_sum = comma_ff + 4'd1;
   assign miss_sum  = miss_ff + 16'd1;
   // zero timeout behaves like one
   assign limit     = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign idx_next  = {1'b0, char_ff} + 5'd1;
   assign len       = (field_mode_ff == nrfe_pkg::MODE_LON) ? nrfe_pkg::LEN_LON
                                                            : nrfe_pkg::LEN_OTHER;

   always_comb begin
      phase_in   = phase_ff;
      comma_in   = comma_ff;
      char_in    = char_ff;
      miss_in    = miss_ff;
      discard_in = discard_ff;
      result     = '0;
      if (in_accept) begin
         if (req_data.opcode == nrfe_pkg::OP_START) begin
            phase_in   = nrfe_pkg::PH_HUNT;
            comma_in   = 4'd0;
            char_in    = 4'd0;
            miss_in    = 16'd0;
            discard_in = 3'd0;
         end else begin
            case (phase_ff)
               nrfe_pkg::PH_HUNT: begin
                  if (b == nrfe_pkg::CH_C) begin
                     comma_in = 4'd0;
                     char_in  = 4'd0;
                     phase_in = is_time ? nrfe_pkg::PH_SKIP : nrfe_pkg::PH_COMMAS;
                  end else begin
                     miss_in = miss_sum;
                     if (miss_sum >= limit) begin
                        if (is_time) begin
                           phase_in   = nrfe_pkg::PH_DISCARD;
                           discard_in = nrfe_pkg::DISCARD_LEN;
                        end else begin
                           phase_in = nrfe_pkg::PH_IDLE;
                        end
                        result.valid         = 1'b1;
                        result.data.out_kind = nrfe_pkg::KIND_TIMEOUT;
                        result.data.last     = 1'b1;
                     end
                  end
               end
               nrfe_pkg::PH_SKIP: begin
                  char_in  = 4'd0;
                  phase_in = nrfe_pkg::PH_CAPTURE;
               end
               nrfe_pkg::PH_COMMAS: begin
                  if (b == nrfe_pkg::CH_COMMA) begin
                     comma_in = comma_sum;
                     if (comma_sum >= nrfe_pkg::comma_target(field_mode_ff)) begin
                        comma_in = 4'd0;
                        if (field_mode_ff == nrfe_pkg::MODE_STATUS) begin
                           phase_in = nrfe_pkg::PH_STATUS;
                        end else begin
                           // time mode keeps its index for the date half
                           if (!is_time) char_in = 4'd0;
                           phase_in = nrfe_pkg::PH_CAPTURE;
                        end
                     end
                  end
               end
               nrfe_pkg::PH_STATUS: begin
                  if (b == nrfe_pkg::CH_A) begin
                     phase_in             = nrfe_pkg::PH_IDLE;
                     result.valid         = 1'b1;
                     result.data.out_kind = nrfe_pkg::KIND_FIX;
                     result.data.last     = 1'b1;
                  end else begin
                     phase_in = nrfe_pkg::PH_HUNT;
                  end
               end
               nrfe_pkg::PH_CAPTURE: begin
                  result.valid          = 1'b1;
                  result.data.out_kind  = nrfe_pkg::KIND_CHAR;
                  result.data.out_char  = b;
                  result.data.out_index = char_ff;
                  if (is_time && char_ff == nrfe_pkg::TIME_END) begin
                     char_in  = nrfe_pkg::DATE_START;
                     comma_in = 4'd0;
                     phase_in = nrfe_pkg::PH_COMMAS;
                  end else if (idx_next >= len) begin
                     result.data.last = 1'b1;
                     char_in          = 4'd0;
                     if (is_time) begin
                        phase_in   = nrfe_pkg::PH_DISCARD;
                        discard_in = nrfe_pkg::DISCARD_LEN;
                     end else begin
                        phase_in = nrfe_pkg::PH_IDLE;
                     end
                  end else begin
                     char_in = idx_next[3:0];
                  end
               end
               nrfe_pkg::PH_DISCARD: begin
                  if (discard_ff <= 3'd1) begin
                     discard_in = 3'd0;
                     phase_in   = nrfe_pkg::PH_IDLE;
                  end else begin
                     discard_in = discard_ff - 3'd1;
                  end
               end
               default: phase_in = nrfe_pkg::PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nrfe_pkg::PH_IDLE;
         comma_ff   <= 4'd0;
         char_ff    <= 4'd0;
         miss_ff    <= 16'd0;
         discard_ff <= 3'd0;
      end else begin
         phase_ff   <= phase_in;
         comma_ff   <= comma_in;
         char_ff    <= char_in;
         miss_ff    <= miss_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// ===== design/nrfe_out_reg.sv =====
module nrfe_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  nrfe_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output nrfe_pkg::rsp_type    rsp_data,
   output logic                 busy
);

   logic              valid_ff, valid_in;
   nrfe_pkg::rsp_type data_ff, data_in;

   // a held response blocks new requests only while it is stalled
   assign busy = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (result.valid) begin
         valid_in = 1'b1;
         data_in  = result.data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== design/nmea_rmc_field_extractor_top.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  nrfe_pkg::req_type (opcode, rx_byte)
// rsp       out        rsp_valid / rsp_stall  nrfe_pkg::rsp_type (kind, char, index, last)
// csr       in         csr_we                 csr_index, csr_data
//
// One request per cycle while req_stall is low; its response, if any, is registered and shows in the next cycle.
// The sentence state machine updates in the cycle the request is taken.
// req_stall is high only while a response sits in the output register and rsp_stall is high.
// Synchronous active-high reset: state goes idle, field_mode 0, timeout_bytes 3960.
module nmea_rmc_field_extractor_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nrfe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nrfe_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);

   nrfe_pkg::result_type result;
   logic                 busy;
   logic                 in_accept;

   assign req_stall = busy;
   assign in_accept = req_valid && !busy;

   nrfe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   nrfe_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (busy)
   );

endmodule

// ===== design/nrfe_checker.sv =====
`include "nmea_rmc_field_extractor_top_assert.svh"

module nrfe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input nrfe_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input nrfe_pkg::rsp_type rsp_data
);

   `NRFE_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `NRFE_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a blocked response")
   `NRFE_ASSERT_IMP(a_status_last, rsp_valid && rsp_data.out_kind != nrfe_pkg::KIND_CHAR, rsp_data.last && rsp_data.out_char == 8'd0 && rsp_data.out_index == 4'd0, "fix or timeout response malformed")
   `NRFE_ASSERT_NXT(a_start_quiet, req_valid && !req_stall && req_data.opcode == nrfe_pkg::OP_START, !rsp_valid, "start request produced a response")

endmodule

bind nmea_rmc_field_extractor_top nrfe_checker u_nrfe_checker (.*);
